[sv/csa_pkg.sv]
// ----------------------------------------------------------------------------
// csa_pkg: shared types and constants for the coefficient scan address block
// Scan type codes, subblock geometry and the diagonal scan table builder.
// ----------------------------------------------------------------------------
package csa_pkg;

  typedef enum logic [1:0] {
    SCAN_UPRIGHT = 2'd0,
    SCAN_HORZ    = 2'd1,
    SCAN_VERT    = 2'd2,
    SCAN_BAD     = 2'd3
  } scan_type_t;

  localparam int LOG2_WIDTH_W = 3;
  localparam int POS_W        = 10;
  localparam int LOG2_SUB     = 2;   // 4x4 subblocks
  localparam int SUB_SIDE     = 4;
  localparam int GRID_MAX     = 8;   // subblocks per side at width 32
  localparam int COORD_W      = 3;

  // One entry per scan position: {col, row}
  typedef logic [2*COORD_W-1:0] diag_cell_t;
  typedef diag_cell_t [GRID_MAX*GRID_MAX-1:0] diag_tab_t;

  // Up-right diagonal scan of an n x n grid, evaluated at elaboration only.
  function automatic diag_tab_t diag_table(int n);
    diag_tab_t tab;
    int        count;
    int        yhi;
    int        ylo;
    tab   = '0;
    count = 0;
    for (int d = 0; d < 2 * n - 1; d++) begin
      yhi = (d < n) ? d : n - 1;
      ylo = (d + 1 > n) ? d + 1 - n : 0;
      for (int y = yhi; y >= ylo; y--) begin
        tab[count] = {COORD_W'(d - y), COORD_W'(y)};
        count++;
      end
    end
    return tab;
  endfunction

endpackage

[sv/csa_addr_map.sv]
// ----------------------------------------------------------------------------
// csa_addr_map: scan position to raster address
// Combinational mapping for diagonal, horizontal and vertical scans.
// ----------------------------------------------------------------------------
module csa_addr_map #(
  parameter int MAX_LOG2_WIDTH = 5
) (
  input  logic [csa_pkg::LOG2_WIDTH_W-1:0] log2_width,
  input  logic [1:0]                       scan_type,
  input  logic [csa_pkg::POS_W-1:0]        scan_pos,
  output logic [csa_pkg::POS_W-1:0]        raster_addr,
  output logic                             bad_request
);

  localparam csa_pkg::diag_tab_t DIAG2 = csa_pkg::diag_table(2);
  localparam csa_pkg::diag_tab_t DIAG4 = csa_pkg::diag_table(4);
  localparam csa_pkg::diag_tab_t DIAG8 = csa_pkg::diag_table(8);

  logic [5:0] blk;
  logic [3:0] inner;
  logic [1:0] gl;
  logic [2:0] bx, by;
  logic [1:0] ix, iy;
  logic [4:0] row, col;
  logic [csa_pkg::POS_W-1:0] addr_big;
  logic [csa_pkg::POS_W-1:0] addr_w2;
  logic       width_ok;
  logic       out_of_block;
  csa_pkg::diag_cell_t grid_cell;
  csa_pkg::diag_cell_t sub_cell;
  csa_pkg::diag_cell_t w2_cell;

  assign blk   = scan_pos[9:4];
  assign inner = scan_pos[3:0];
  assign gl    = 2'(log2_width - 3'd2);

  assign width_ok = (log2_width >= 3'd1) &&
                    (32'(log2_width) <= MAX_LOG2_WIDTH);

  always_comb begin
    unique case (log2_width)
      3'd1:    out_of_block = (scan_pos[9:2] != '0);
      3'd2:    out_of_block = (scan_pos[9:4] != '0);
      3'd3:    out_of_block = (scan_pos[9:6] != '0);
      3'd4:    out_of_block = (scan_pos[9:8] != '0);
      default: out_of_block = 1'b0;
    endcase
  end

  always_comb begin
    unique case (log2_width)
      3'd3:    grid_cell = DIAG2[blk[1:0]];
      3'd4:    grid_cell = DIAG4[blk[3:0]];
      3'd5:    grid_cell = DIAG8[blk];
      default: grid_cell = '0;
    endcase
  end

  assign sub_cell = DIAG4[inner];
  assign w2_cell  = DIAG2[scan_pos[1:0]];

  // Subblock and in-subblock coordinates
  always_comb begin
    unique case (scan_type)
      csa_pkg::SCAN_HORZ: begin
        bx = 3'(blk & ((6'd1 << gl) - 6'd1));
        by = 3'(blk >> gl);
        ix = inner[1:0];
        iy = inner[3:2];
      end
      csa_pkg::SCAN_VERT: begin
        by = 3'(blk & ((6'd1 << gl) - 6'd1));
        bx = 3'(blk >> gl);
        iy = inner[1:0];
        ix = inner[3:2];
      end
      default: begin
        bx = grid_cell[5:3];
        by = grid_cell[2:0];
        ix = sub_cell[4:3];
        iy = sub_cell[1:0];
      end
    endcase
  end

  assign row = {by, iy};
  assign col = {bx, ix};
  assign addr_big = (csa_pkg::POS_W'(row) << log2_width) | csa_pkg::POS_W'(col);

  // Width 2: whole-block orders
  always_comb begin
    unique case (scan_type)
      csa_pkg::SCAN_HORZ: addr_w2 = {8'd0, scan_pos[1:0]};
      csa_pkg::SCAN_VERT: addr_w2 = {8'd0, scan_pos[0], scan_pos[1]};
      default:            addr_w2 = {8'd0, w2_cell[1:0] == 2'd1, w2_cell[3]};
    endcase
  end

  assign bad_request = !width_ok || (scan_type == csa_pkg::SCAN_BAD) || out_of_block;

  always_comb begin
    if (bad_request) begin
      raster_addr = '0;
    end else if (log2_width == 3'd1) begin
      raster_addr = addr_w2;
    end else begin
      raster_addr = addr_big;
    end
  end

endmodule

[sv/coefficient_scan_address.sv]
// ----------------------------------------------------------------------------
// coefficient_scan_address: coefficient scan position to raster address
// Input register, table-based mapping, result register.
// ----------------------------------------------------------------------------
// Path: an accepted transaction passes the input register, then the result register.
// Throughput: one transaction per cycle; the input stage loads when empty or
// when its transaction moves on, so a held result stalls the input once full.
// Reset: synchronous, clears both stage valid flags; no table or pipeline
// payload is cleared.
module coefficient_scan_address #(
  parameter int MAX_LOG2_WIDTH = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [csa_pkg::LOG2_WIDTH_W-1:0] log2_width,
  input  logic [1:0]                       scan_type,
  input  logic [csa_pkg::POS_W-1:0]        scan_pos,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [csa_pkg::POS_W-1:0]        raster_addr,
  output logic                             bad_request
);

  logic                             s1_valid;
  logic [csa_pkg::LOG2_WIDTH_W-1:0] s1_log2_width;
  logic [1:0]                       s1_scan_type;
  logic [csa_pkg::POS_W-1:0]        s1_scan_pos;
  logic [csa_pkg::POS_W-1:0]        map_addr;
  logic                             map_bad;
  logic                             s2_load;
  logic                             s1_load;

  assign s2_load  = s1_valid && (!out_valid || !out_stall);
  assign s1_load  = !s1_valid || s2_load;
  assign in_stall = !s1_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load && in_valid) begin
      s1_log2_width <= log2_width;
      s1_scan_type  <= scan_type;
      s1_scan_pos   <= scan_pos;
    end
  end

  csa_addr_map #(
    .MAX_LOG2_WIDTH(MAX_LOG2_WIDTH)
  ) u_map (
    .log2_width (s1_log2_width),
    .scan_type  (s1_scan_type),
    .scan_pos   (s1_scan_pos),
    .raster_addr(map_addr),
    .bad_request(map_bad)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s2_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_load) begin
      raster_addr <= map_addr;
      bad_request <= map_bad;
    end
  end

endmodule

[sim/scan_address_check.sv]
// ----------------------------------------------------------------------------
// scan_address_check: result predictor and comparator for the scan address block
// Watches both channels, computes the raster address of every accepted request,
// and compares each returned transaction in order against the oldest prediction.
// ----------------------------------------------------------------------------
module scan_address_check #(
  parameter int MAX_LOG2_WIDTH = 5
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [csa_pkg::LOG2_WIDTH_W-1:0] log2_width,
  input  logic [1:0]                       scan_type,
  input  logic [csa_pkg::POS_W-1:0]        scan_pos,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [csa_pkg::POS_W-1:0]        raster_addr,
  input  logic                             bad_request,
  output int                               fail_count,
  output int                               pending,
  output int                               result_count,
  output int                               bad_count
);

  typedef struct packed {
    logic [csa_pkg::POS_W-1:0] addr;
    logic                      bad;
  } scan_result_t;

  scan_result_t expected_q[$];

  // Up-right diagonal walk of an n x n grid: each diagonal starts bottom-left.
  function automatic void diag_walk(input int n, input int p, output int col, output int row);
    int count;
    int yhi;
    int ylo;
    count = 0;
    col   = 0;
    row   = 0;
    for (int d = 0; d + 1 < 2 * n; d++) begin
      yhi = (d < n) ? d : n - 1;
      ylo = (d + 1 > n) ? d + 1 - n : 0;
      for (int y = yhi; y >= ylo; y--) begin
        if (count == p) begin
          col = d - y;
          row = y;
          return;
        end
        count++;
      end
    end
  endfunction

  function automatic scan_result_t map_position(
      input logic [csa_pkg::LOG2_WIDTH_W-1:0] lw,
      input logic [1:0]                       st,
      input logic [csa_pkg::POS_W-1:0]        pos);
    scan_result_t res;
    int width;
    int grid_log2;
    int grid;
    int blk;
    int inner;
    int bx;
    int by;
    int ix;
    int iy;
    res = '0;
    if (lw < 1 || lw > MAX_LOG2_WIDTH ||
        csa_pkg::scan_type_t'(st) == csa_pkg::SCAN_BAD) begin
      res.bad = 1'b1;
    end else begin
      width = 1 << lw;
      if (int'(pos) >= width * width) begin
        res.bad = 1'b1;
      end else if (lw == 1) begin
        // 2x2 block: whole-block orders, no subblocks
        case (csa_pkg::scan_type_t'(st))
          csa_pkg::SCAN_UPRIGHT: begin
            diag_walk(2, int'(pos), ix, iy);
            res.addr = csa_pkg::POS_W'(iy * 2 + ix);
          end
          csa_pkg::SCAN_HORZ: res.addr = pos;
          default:   res.addr = csa_pkg::POS_W'(int'(pos[0]) * 2 + int'(pos[1]));
        endcase
      end else begin
        grid_log2 = lw - csa_pkg::LOG2_SUB;
        grid      = 1 << grid_log2;
        blk       = int'(pos) / (csa_pkg::SUB_SIDE * csa_pkg::SUB_SIDE);
        inner     = int'(pos) % (csa_pkg::SUB_SIDE * csa_pkg::SUB_SIDE);
        case (csa_pkg::scan_type_t'(st))
          csa_pkg::SCAN_UPRIGHT: begin
            diag_walk(grid, blk, bx, by);
            diag_walk(csa_pkg::SUB_SIDE, inner, ix, iy);
          end
          csa_pkg::SCAN_HORZ: begin
            bx = blk & (grid - 1);
            by = blk >> grid_log2;
            ix = inner & (csa_pkg::SUB_SIDE - 1);
            iy = inner >> csa_pkg::LOG2_SUB;
          end
          default: begin
            by = blk & (grid - 1);
            bx = blk >> grid_log2;
            iy = inner & (csa_pkg::SUB_SIDE - 1);
            ix = inner >> csa_pkg::LOG2_SUB;
          end
        endcase
        res.addr = csa_pkg::POS_W'((by * csa_pkg::SUB_SIDE + iy) * width +
                                   bx * csa_pkg::SUB_SIDE + ix);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    scan_result_t want;
    if (rst) begin
      pending <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count++;
        if (bad_request) bad_count++;
        if (expected_q.size() == 0) begin
          if (fail_count < 10)
            $display("%0t: result with nothing outstanding: addr=%0d bad=%0b",
                     $time, raster_addr, bad_request);
          fail_count++;
        end else begin
          want = expected_q.pop_front();
          if (raster_addr !== want.addr || bad_request !== want.bad) begin
            if (fail_count < 10)
              $display("%0t: mismatch: expected addr=%0d bad=%0b, got addr=%0d bad=%0b",
                       $time, want.addr, want.bad, raster_addr, bad_request);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_q.push_back(map_position(log2_width, scan_type, scan_pos));
      pending <= expected_q.size();
    end
  end

endmodule

[sim/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: testbench for coefficient_scan_address
// Directed corner requests, then random requests under four sender-idle and
// receiver-stall mixes, draining between mixes; the checker does the scoring.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int MAX_LOG2     = 5;
  localparam int PHASE_ITEMS  = 283;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int LATENCY_WAIT = 8;

  logic                             clk         = 1'b0;
  logic                             rst         = 1'b1;
  logic                             in_valid    = 1'b0;
  logic                             in_stall;
  logic [csa_pkg::LOG2_WIDTH_W-1:0] log2_width  = '0;
  logic [1:0]                       scan_type   = '0;
  logic [csa_pkg::POS_W-1:0]        scan_pos    = '0;
  logic                             out_valid;
  logic                             out_stall   = 1'b0;
  logic [csa_pkg::POS_W-1:0]        raster_addr;
  logic                             bad_request;

  int gap_pct   = 0;
  int stall_pct = 0;
  int cycles    = 0;
  int fail_count;
  int pending;
  int result_count;
  int bad_count;

  coefficient_scan_address #(.MAX_LOG2_WIDTH(MAX_LOG2)) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .log2_width  (log2_width),
    .scan_type   (scan_type),
    .scan_pos    (scan_pos),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .raster_addr (raster_addr),
    .bad_request (bad_request)
  );

  scan_address_check #(.MAX_LOG2_WIDTH(MAX_LOG2)) addr_check (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .log2_width   (log2_width),
    .scan_type    (scan_type),
    .scan_pos     (scan_pos),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .raster_addr  (raster_addr),
    .bad_request  (bad_request),
    .fail_count   (fail_count),
    .pending      (pending),
    .result_count (result_count),
    .bad_count    (bad_count)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    cycles    <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("[coefficient_scan_address] ERROR");
      $finish;
    end
  end

  // Present one transaction, hold it until accepted, then maybe go idle.
  task automatic send_request(input logic [csa_pkg::LOG2_WIDTH_W-1:0] lw,
                              input logic [1:0] st,
                              input logic [csa_pkg::POS_W-1:0] pos);
    in_valid   <= 1'b1;
    log2_width <= lw;
    scan_type  <= st;
    scan_pos   <= pos;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic send_random();
    logic [csa_pkg::LOG2_WIDTH_W-1:0] lw;
    logic [1:0]                       st;
    logic [csa_pkg::POS_W-1:0]        pos;
    // mostly legal widths, a few unsupported ones
    if ($urandom_range(99) < 6)
      lw = ($urandom_range(2) == 0) ? 3'd0 : csa_pkg::LOG2_WIDTH_W'($urandom_range(6, 7));
    else
      lw = csa_pkg::LOG2_WIDTH_W'($urandom_range(1, MAX_LOG2));
    st = ($urandom_range(99) < 8) ? csa_pkg::SCAN_BAD : 2'($urandom_range(0, 2));
    if (lw >= 1 && lw <= MAX_LOG2 && $urandom_range(99) >= 10)
      pos = csa_pkg::POS_W'($urandom_range(0, (1 << (2 * lw)) - 1));
    else
      pos = csa_pkg::POS_W'($urandom);
    send_request(lw, st, pos);
  endtask

  // Stop sending and wait for every outstanding result.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // width 2: every diagonal position, raster and column orders
    for (int p = 0; p < 4; p++) send_request(3'd1, csa_pkg::SCAN_UPRIGHT, csa_pkg::POS_W'(p));
    send_request(3'd1, csa_pkg::SCAN_HORZ, 10'd2);
    send_request(3'd1, csa_pkg::SCAN_VERT, 10'd1);
    // last positions and subblock crossings
    send_request(3'd2, csa_pkg::SCAN_UPRIGHT, 10'd15);
    send_request(3'd3, csa_pkg::SCAN_UPRIGHT, 10'd17);
    send_request(3'd5, csa_pkg::SCAN_UPRIGHT, 10'd0);
    send_request(3'd5, csa_pkg::SCAN_UPRIGHT, 10'd1023);
    send_request(3'd5, csa_pkg::SCAN_HORZ, 10'd1023);
    send_request(3'd5, csa_pkg::SCAN_VERT, 10'd1023);
    send_request(3'd4, csa_pkg::SCAN_HORZ, 10'd100);
    send_request(3'd4, csa_pkg::SCAN_VERT, 10'd100);
    // error cases: invalid scan, position past block, unsupported widths
    send_request(3'd5, csa_pkg::SCAN_BAD, 10'd0);
    send_request(3'd2, csa_pkg::SCAN_UPRIGHT, 10'd16);
    send_request(3'd1, csa_pkg::SCAN_HORZ, 10'd4);
    send_request(3'd0, csa_pkg::SCAN_UPRIGHT, 10'd0);
    send_request(3'd6, csa_pkg::SCAN_VERT, 10'd0);
    send_request(3'd7, csa_pkg::SCAN_BAD, 10'd1023);
    wait_idle();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 50; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 50; end
        default: begin gap_pct = 16; stall_pct = 16; end
      endcase
      repeat (PHASE_ITEMS) send_random();
      wait_idle();
    end

    stall_pct = 0;
    repeat (LATENCY_WAIT) @(posedge clk);

    $display("covered %0d scan requests (%0d flagged bad) over directed corners and",
             result_count, bad_count);
    $display("four idle/stall mixes, draining fully between mixes; %0d mismatches",
             fail_count);
    if (fail_count == 0)
      $display("[coefficient_scan_address] OK");
    else
      $display("[coefficient_scan_address] ERROR");
    $finish;
  end

endmodule

[coefficient_scan_address.f]
sv/csa_pkg.sv
sv/csa_addr_map.sv
sv/coefficient_scan_address.sv
sim/scan_address_check.sv
sim/tb_top.sv
